// File: rtl/core/lfs_pkg.sv
package lfs_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int ID_WIDTH    = 16;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] OP_QUERY  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	// Controller to datapath
	typedef struct packed {
		logic accept;
		logic update;
		logic scan_rd;
		logic load_out;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic empty;
		logic scan_at_tail;
		logic out_free;
	} sts_t;

	// Result word, status in the lowest bits
	typedef struct packed {
		logic                key_found;
		logic [CNT_W-1:0]    even_count;
		logic [CNT_W-1:0]    occupancy;
		logic                head_valid;
		logic [ID_WIDTH-1:0] head_id;
		logic [ID_WIDTH-1:0] removed_id;
		logic [1:0]          status;
	} out_t;

endpackage

// File: rtl/core/lfs_ctrl.sv
module lfs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  lfs_pkg::sts_t sts,
	output lfs_pkg::cmd_t cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_UPD   = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_DRAIN = 3'd3;
	localparam logic [2:0] S_RES   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nx;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_nx     = state_q;
		cmd.accept   = 1'b0;
		cmd.update   = 1'b0;
		cmd.scan_rd  = 1'b0;
		cmd.load_out = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_nx   = S_UPD;
				end
			end
			S_UPD: begin
				cmd.update = 1'b1;
				state_nx   = S_SCAN;
			end
			S_SCAN: begin
				if (sts.empty) begin
					state_nx = S_RES;
				end else begin
					cmd.scan_rd = 1'b1;
					if (sts.scan_at_tail) begin
						state_nx = S_DRAIN;
					end
				end
			end
			S_DRAIN: begin
				state_nx = S_RES;
			end
			S_RES: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

// File: rtl/core/lfs_dp.sv
module lfs_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lfs_pkg::cmd_t                 cmd,
	output lfs_pkg::sts_t                 sts,
	input  logic [1:0]                    in_op,
	input  logic [lfs_pkg::ID_WIDTH-1:0]  in_key,
	output lfs_pkg::out_t                 out_data,
	output logic                          out_valid,
	input  logic                          out_ready
);

	logic [1:0]                   op_q;
	logic [lfs_pkg::ID_WIDTH-1:0] key_q;

	logic [lfs_pkg::ID_WIDTH-1:0] mem_q [lfs_pkg::QUEUE_DEPTH];
	logic [lfs_pkg::ID_WIDTH-1:0] rd_data_q;
	logic [lfs_pkg::IDX_W-1:0]    rd_addr;
	logic                         rd_vld_q;

	logic [lfs_pkg::IDX_W-1:0]    head_q, tail_q, scan_idx_q;
	logic                         empty_q;

	logic [lfs_pkg::IDX_W-1:0]    head_nx, tail_nx, wr_addr;
	logic                         empty_nx, wr_en;
	logic [1:0]                   status_nx;
	logic [lfs_pkg::ID_WIDTH-1:0] removed_nx;

	logic [1:0]                   status_q;
	logic [lfs_pkg::ID_WIDTH-1:0] removed_q, head_id_q;
	logic [lfs_pkg::CNT_W-1:0]    occ_q, evens_q;
	logic                         found_q, first_q;

	lfs_pkg::out_t                out_q;
	logic                         out_valid_q;

	// Queue update for the latched operation
	always_comb begin
		head_nx    = head_q;
		tail_nx    = tail_q;
		empty_nx   = empty_q;
		wr_en      = 1'b0;
		wr_addr    = tail_q + lfs_pkg::IDX_W'(1);
		status_nx  = lfs_pkg::ST_OK;
		removed_nx = '0;
		unique case (op_q)
			lfs_pkg::OP_APPEND: begin
				if (empty_q) begin
					head_nx  = '0;
					tail_nx  = '0;
					empty_nx = 1'b0;
					wr_en    = 1'b1;
					wr_addr  = '0;
				end else if (tail_q == lfs_pkg::IDX_W'(lfs_pkg::QUEUE_DEPTH - 1)) begin
					status_nx = lfs_pkg::ST_FULL;
				end else begin
					tail_nx = tail_q + lfs_pkg::IDX_W'(1);
					wr_en   = 1'b1;
				end
			end
			lfs_pkg::OP_REMOVE: begin
				if (empty_q) begin
					status_nx = lfs_pkg::ST_EMPTY;
				end else begin
					removed_nx = rd_data_q;
					if (head_q >= tail_q) begin
						head_nx  = '0;
						tail_nx  = '0;
						empty_nx = 1'b1;
					end else begin
						head_nx = head_q + lfs_pkg::IDX_W'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Outside the scan, read the head slot so a remove sees its entry
	assign rd_addr = cmd.scan_rd ? scan_idx_q : head_q;

	always_ff @(posedge clk) begin
		if (cmd.update && wr_en) begin
			mem_q[wr_addr] <= key_q;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q  <= in_op;
			key_q <= in_key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			empty_q  <= 1'b1;
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= cmd.scan_rd;
			if (cmd.update) begin
				head_q  <= head_nx;
				tail_q  <= tail_nx;
				empty_q <= empty_nx;
			end
		end
	end

	// Scan index and accumulators
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			scan_idx_q <= head_nx;
			status_q   <= status_nx;
			removed_q  <= removed_nx;
			head_id_q  <= '0;
			occ_q      <= '0;
			evens_q    <= '0;
			found_q    <= 1'b0;
			first_q    <= 1'b1;
		end else begin
			if (cmd.scan_rd) begin
				scan_idx_q <= scan_idx_q + lfs_pkg::IDX_W'(1);
			end
			if (rd_vld_q) begin
				first_q <= 1'b0;
				if (first_q) begin
					head_id_q <= rd_data_q;
				end
				occ_q   <= occ_q + lfs_pkg::CNT_W'(1);
				evens_q <= evens_q + {{(lfs_pkg::CNT_W-1){1'b0}}, ~rd_data_q[0]};
				if (rd_data_q == key_q) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.status     <= status_q;
			out_q.removed_id <= removed_q;
			out_q.head_id    <= head_id_q;
			out_q.head_valid <= ~empty_q;
			out_q.occupancy  <= occ_q;
			out_q.even_count <= evens_q;
			out_q.key_found  <= found_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.empty        = empty_q;
	assign sts.scan_at_tail = (scan_idx_q == tail_q);
	assign sts.out_free     = ~out_valid_q | out_ready;

	assign out_data  = out_q;
	assign out_valid = out_valid_q;

endmodule

// File: rtl/core/linear_fifo_with_search.sv
// Linear array queue of IDs with a presence search.
// Input channel (s_*): one transfer carries an operation (query, append,
// remove head) and an ID that is appended on append and is the search key
// on every operation. Output channel (m_*): one transfer per input item
// with status, removed ID, head ID and valid, occupancy, count of even
// IDs and the found flag, all describing the queue after the operation.
// The queue is linear: append is refused once the tail reaches the last
// slot, even when earlier slots were freed; removing the last ID returns
// both indices to slot 0.
// Sequence: after an input transfer the item passes the update state, then
// the scan, which reads one entry of the store per cycle from head to
// tail, then the drain state (skipped on an empty queue) and the result
// state, which loads the output register. A new input is taken only once
// that load is done, so one item is in flight at a time.
// The result sits in an output register; a stalled receiver holds it
// there while the next item is already taken in and processed, and only
// the final load waits for the register to free up.
// Reset clears the indices and marks the queue empty; stored IDs are not
// cleared and are never read before being written.
module linear_fifo_with_search (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // operation[1:0], patient_id[17:2], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata    // status[1:0], removed_id[17:2], head_id[33:18],
	                               // head_valid[34], occupancy[39:35],
	                               // even_count[44:40], key_found[45], zero pad
);

	lfs_pkg::cmd_t cmd;
	lfs_pkg::sts_t sts;
	lfs_pkg::out_t out_data;

	// Sequence the item: accept, update, scan, drain, result
	lfs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Hold the store, indices, scan accumulators and the output register
	lfs_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_op     (s_tdata[1:0]),
		.in_key    (s_tdata[2 +: lfs_pkg::ID_WIDTH]),
		.out_data  (out_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready)
	);

	// Pad the result word to whole bytes
	assign m_tdata = {2'b00, out_data};

	// One item in flight: after an input transfer, drop ready for the update
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in progress");

	// Head is valid exactly when the queue holds at least one ID
	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (out_data.head_valid == (out_data.occupancy != '0)))
		else $error("head_valid disagrees with occupancy");

	// Counts stay within the store
	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (out_data.occupancy <= lfs_pkg::CNT_W'(lfs_pkg::QUEUE_DEPTH))
		&& (out_data.even_count <= out_data.occupancy))
		else $error("occupancy or even count out of range");

	// A refused append leaves a non-empty queue; a refused remove an empty one
	a_refusals: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((out_data.status != lfs_pkg::ST_FULL) || out_data.head_valid)
		&& ((out_data.status != lfs_pkg::ST_EMPTY) || !out_data.head_valid))
		else $error("refusal status inconsistent with queue state");

endmodule
